// ===== rtl/core/gdo_pkg.sv =====
// ---------------------------------------------------------------------------
// gdo_pkg
// widths, calendar constants and small month tables for the date offset unit
// ---------------------------------------------------------------------------
package gdo_pkg;

   localparam int OFFSET_WIDTH = 17;
   localparam int DAY_W        = 5;
   localparam int MONTH_W      = 4;
   localparam int YEAR_W       = 14;
   localparam int WDAY_W       = 3;

   // ordinal counts reach about 6.0e6 plus the offset, signed
   localparam int ACC_W = ((OFFSET_WIDTH > 23) ? OFFSET_WIDTH : 23) + 2;

   localparam int DAYS_400      = 146097;
   localparam int DAYS_100      = 36524;
   localparam int DAYS_4        = 1461;
   localparam int DAYS_1        = 365;
   localparam int LAST_ORDINAL  = 3652059;

   // leap-aware month length, 28..31
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         4'd2:                    len = leap ? 5'd29 : 5'd28;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

   // days in the months before m, not counting a leap day
   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
      logic [8:0] d;
      case (m)
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // residue mod 7 of a narrow value below 42
   function automatic logic [WDAY_W-1:0] mod7(input logic [5:0] v);
      logic [5:0] r;
      r = v;
      for (int i = 0; i < 5; i++) begin
         if (r >= 6'd7) begin
            r = r - 6'd7;
         end
      end
      return r[WDAY_W-1:0];
   endfunction

endpackage

// ===== rtl/core/gregorian_date_offset_unit.sv =====
// ---------------------------------------------------------------------------
// gregorian_date_offset_unit
// shifts a gregorian date by a signed day count and returns its weekday
// ---------------------------------------------------------------------------
// flow: start date to ordinal day through 400/100/4/1-year blocks and the day
//   of month, offset added and range checked, then back through the year blocks
//   and the month walk on the shared adder; out of range skips the walk back
// req_stall holds off a new item until the result is loaded; rsp_stall can hold that
// reset: synchronous, active high; clears the sequencer and rsp_valid
// ---------------------------------------------------------------------------
module gregorian_date_offset_unit
   import gdo_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [DAY_W-1:0]               req_start_day,
   input  logic [MONTH_W-1:0]             req_start_month,
   input  logic [YEAR_W-1:0]              req_start_year,
   input  logic signed [OFFSET_WIDTH-1:0] req_day_offset,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [DAY_W-1:0]               rsp_result_day,
   output logic [MONTH_W-1:0]             rsp_result_month,
   output logic [YEAR_W-1:0]              rsp_result_year,
   output logic [WDAY_W-1:0]              rsp_result_weekday,
   output logic                           rsp_out_of_range
);

   // sequencer codes
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_F400 = 4'd1;   // start date to ordinal day
   localparam logic [3:0] S_F100 = 4'd2;
   localparam logic [3:0] S_F4   = 4'd3;
   localparam logic [3:0] S_F1   = 4'd4;
   localparam logic [3:0] S_FDAY = 4'd5;   // day of month and earlier months
   localparam logic [3:0] S_OFS  = 4'd6;   // add the offset
   localparam logic [3:0] S_CHK  = 4'd7;   // range check, ordinal to zero based
   localparam logic [3:0] S_B400 = 4'd8;   // ordinal day back to a date
   localparam logic [3:0] S_B100 = 4'd9;
   localparam logic [3:0] S_B4   = 4'd10;
   localparam logic [3:0] S_B1   = 4'd11;
   localparam logic [3:0] S_BMON = 4'd12;  // month walk inside the year
   localparam logic [3:0] S_DONE = 4'd13;  // wait for the output register

   localparam logic signed [ACC_W-1:0] K_400  = ACC_W'(DAYS_400);
   localparam logic signed [ACC_W-1:0] K_100  = ACC_W'(DAYS_100);
   localparam logic signed [ACC_W-1:0] K_4    = ACC_W'(DAYS_4);
   localparam logic signed [ACC_W-1:0] K_1    = ACC_W'(DAYS_1);
   localparam logic signed [ACC_W-1:0] K_ONE  = ACC_W'(1);
   localparam logic signed [ACC_W-1:0] K_LAST = ACC_W'(LAST_ORDINAL - 1);

   logic [3:0]                    state_ff, state_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;       // running day count
   logic [YEAR_W-1:0]             yr_ff, yr_in;         // years left, then years built
   logic [DAY_W-1:0]              day_ff, day_in;       // start day, then result day
   logic [MONTH_W-1:0]            mon_ff, mon_in;
   logic signed [OFFSET_WIDTH-1:0] ofs_ff, ofs_in;
   logic                          leap_ff, leap_in;
   logic                          r99_ff, r99_in;       // year-1 mod 100 is 99
   logic [1:0]                    q100_ff, q100_in;
   logic [4:0]                    q4_ff, q4_in;
   logic [1:0]                    q1_ff, q1_in;
   logic [WDAY_W-1:0]             wk_ff, wk_in;         // weekday residue so far
   logic                          oor_ff, oor_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [DAY_W-1:0]              rsp_day_ff, rsp_day_in;
   logic [MONTH_W-1:0]            rsp_mon_ff, rsp_mon_in;
   logic [YEAR_W-1:0]             rsp_yr_ff, rsp_yr_in;
   logic [WDAY_W-1:0]             rsp_wk_ff, rsp_wk_in;
   logic                          rsp_oor_ff, rsp_oor_in;

   // shared adder
   logic signed [ACC_W-1:0]       operand;
   logic signed [ACC_W-1:0]       sum;
   logic                          sum_ge0;

   logic                          req_take;
   logic [MONTH_W-1:0]            mon_clamp;
   logic [YEAR_W-1:0]             yr_clamp;
   logic [DAY_W-1:0]              cur_len;
   logic [DAY_W-1:0]              day_clamp;
   logic [9:0]                    day_term;
   logic                          out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // start fields clamp as the setters do
   always_comb begin
      mon_clamp = (req_start_month inside {[4'd1:4'd12]}) ? req_start_month : 4'd1;
      yr_clamp  = (req_start_year == '0) ? YEAR_W'(1) : req_start_year;
   end

   // month length for both the day clamp and the month walk
   assign cur_len   = month_len(mon_ff, leap_ff);
   assign day_clamp = (day_ff == '0 || day_ff > cur_len) ? DAY_W'(1) : day_ff;
   assign day_term  = 10'(day_clamp) + 10'(days_before(mon_ff))
                    + 10'((leap_ff && mon_ff > 4'd2) ? 1 : 0);

   always_comb begin
      case (state_ff)
         S_F400:  operand = K_400;
         S_F100:  operand = K_100;
         S_F4:    operand = K_4;
         S_F1:    operand = K_1;
         S_FDAY:  operand = ACC_W'(day_term);
         S_OFS:   operand = ACC_W'(ofs_ff);
         S_CHK:   operand = -K_ONE;
         S_B400:  operand = -K_400;
         S_B100:  operand = -K_100;
         S_B4:    operand = -K_4;
         S_B1:    operand = -K_1;
         S_BMON:  operand = -(ACC_W'(cur_len));
         default: operand = '0;
      endcase
   end

   assign sum     = acc_ff + operand;
   assign sum_ge0 = !sum[ACC_W-1];

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      yr_in    = yr_ff;
      day_in   = day_ff;
      mon_in   = mon_ff;
      ofs_in   = ofs_ff;
      leap_in  = leap_ff;
      r99_in   = r99_ff;
      q100_in  = q100_ff;
      q4_in    = q4_ff;
      q1_in    = q1_ff;
      wk_in    = wk_ff;
      oor_in   = oor_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_day_in   = rsp_day_ff;
      rsp_mon_in   = rsp_mon_ff;
      rsp_yr_in    = rsp_yr_ff;
      rsp_wk_in    = rsp_wk_ff;
      rsp_oor_in   = rsp_oor_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               day_in   = req_start_day;
               mon_in   = mon_clamp;
               yr_in    = yr_clamp - YEAR_W'(1);
               ofs_in   = req_day_offset;
               acc_in   = '0;
               q100_in  = '0;
               state_in = S_F400;
            end
         end
         // whole 400-year cycles of year-1
         S_F400: begin
            if (yr_ff >= YEAR_W'(400)) begin
               acc_in = sum;
               yr_in  = yr_ff - YEAR_W'(400);
            end else begin
               state_in = S_F100;
            end
         end
         S_F100: begin
            if (yr_ff >= YEAR_W'(100)) begin
               acc_in  = sum;
               yr_in   = yr_ff - YEAR_W'(100);
               q100_in = q100_ff + 2'd1;
            end else begin
               r99_in   = (yr_ff == YEAR_W'(99));
               state_in = S_F4;
            end
         end
         S_F4: begin
            if (yr_ff >= YEAR_W'(4)) begin
               acc_in = sum;
               yr_in  = yr_ff - YEAR_W'(4);
            end else begin
               // year-1 mod 4 is 3: leap unless a century not on 400
               leap_in  = (yr_ff == YEAR_W'(3)) && (!r99_ff || q100_ff == 2'd3);
               state_in = S_F1;
            end
         end
         S_F1: begin
            if (yr_ff != '0) begin
               acc_in = sum;
               yr_in  = yr_ff - YEAR_W'(1);
            end else begin
               state_in = S_FDAY;
            end
         end
         S_FDAY: begin
            acc_in   = sum;
            state_in = S_OFS;
         end
         S_OFS: begin
            acc_in   = sum;
            state_in = S_CHK;
         end
         // sum is the target ordinal minus one
         S_CHK: begin
            if (!sum_ge0 || sum > K_LAST) begin
               oor_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               oor_in   = 1'b0;
               acc_in   = sum;
               yr_in    = YEAR_W'(1);
               wk_in    = WDAY_W'(1);
               q100_in  = '0;
               q4_in    = '0;
               q1_in    = '0;
               state_in = S_B400;
            end
         end
         // 400-year cycles are whole weeks
         S_B400: begin
            if (sum_ge0) begin
               acc_in = sum;
               yr_in  = yr_ff + YEAR_W'(400);
            end else begin
               state_in = S_B100;
            end
         end
         S_B100: begin
            if (sum_ge0 && q100_ff != 2'd3) begin
               acc_in  = sum;
               yr_in   = yr_ff + YEAR_W'(100);
               q100_in = q100_ff + 2'd1;
               wk_in   = mod7(6'(wk_ff) + 6'd5);
            end else begin
               state_in = S_B4;
            end
         end
         S_B4: begin
            if (sum_ge0) begin
               acc_in = sum;
               yr_in  = yr_ff + YEAR_W'(4);
               q4_in  = q4_ff + 5'd1;
               wk_in  = mod7(6'(wk_ff) + 6'd5);
            end else begin
               state_in = S_B1;
            end
         end
         S_B1: begin
            if (sum_ge0 && q1_ff != 2'd3) begin
               acc_in = sum;
               yr_in  = yr_ff + YEAR_W'(1);
               q1_in  = q1_ff + 2'd1;
               wk_in  = mod7(6'(wk_ff) + 6'd1);
            end else begin
               leap_in  = (q1_ff == 2'd3) && (q4_ff != 5'd24 || q100_ff == 2'd3);
               mon_in   = MONTH_W'(1);
               state_in = S_BMON;
            end
         end
         S_BMON: begin
            if (mon_ff != MONTH_W'(12) && sum_ge0) begin
               acc_in = sum;
               mon_in = mon_ff + MONTH_W'(1);
               // month length mod 7 is its excess over four weeks
               wk_in  = mod7(6'(wk_ff) + 6'(cur_len - DAY_W'(28)));
            end else begin
               day_in   = acc_ff[DAY_W-1:0] + DAY_W'(1);
               wk_in    = mod7(6'(wk_ff) + 6'(acc_ff[DAY_W-1:0]));
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_oor_in   = oor_ff;
               rsp_day_in   = oor_ff ? '0 : day_ff;
               rsp_mon_in   = oor_ff ? '0 : mon_ff;
               rsp_yr_in    = oor_ff ? '0 : yr_ff;
               rsp_wk_in    = oor_ff ? '0 : wk_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and result payload, no reset needed
   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      yr_ff      <= yr_in;
      day_ff     <= day_in;
      mon_ff     <= mon_in;
      ofs_ff     <= ofs_in;
      leap_ff    <= leap_in;
      r99_ff     <= r99_in;
      q100_ff    <= q100_in;
      q4_ff      <= q4_in;
      q1_ff      <= q1_in;
      wk_ff      <= wk_in;
      oor_ff     <= oor_in;
      rsp_day_ff <= rsp_day_in;
      rsp_mon_ff <= rsp_mon_in;
      rsp_yr_ff  <= rsp_yr_in;
      rsp_wk_ff  <= rsp_wk_in;
      rsp_oor_ff <= rsp_oor_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_day     = rsp_day_ff;
   assign rsp_result_month   = rsp_mon_ff;
   assign rsp_result_year    = rsp_yr_ff;
   assign rsp_result_weekday = rsp_wk_ff;
   assign rsp_out_of_range   = rsp_oor_ff;

`ifndef SYNTH
   // an accepted item always starts the year reduction
   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_F400))
      else $error("accepted item did not start the sequencer");

   // a flagged result carries no date
   a_oor_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |->
         (rsp_result_day == '0 && rsp_result_month == '0 &&
          rsp_result_year == '0 && rsp_result_weekday == '0))
      else $error("out of range result has nonzero fields");

   // an in-range result is a real calendar date
   a_date_legal : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_of_range) |->
         (rsp_result_day != '0 && rsp_result_month != '0 &&
          rsp_result_month <= MONTH_W'(12) && rsp_result_year != '0 &&
          rsp_result_weekday <= WDAY_W'(6)))
      else $error("result date fields out of range");

   // the output register is only loaded when it is free
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == S_DONE))
      else $error("result left while output register was full");
`endif

endmodule
